[hw/rtl/joystick_arcade_drive_mixer_macros.svh]
// assertion helpers shared by the checker
`ifndef JOYSTICK_ARCADE_DRIVE_MIXER_MACROS_SVH
`define JOYSTICK_ARCADE_DRIVE_MIXER_MACROS_SVH

// implication checked at every rising edge outside reset
`define JADM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jadm assertion failed");

// condition that holds at every rising edge outside reset
`define JADM_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("jadm assertion failed");

`endif

[hw/rtl/jadm_pkg.sv]
`default_nettype none

package jadm_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 12;

  // motor command scale and percentage base
  localparam int unsigned MOTOR_MAX    = 1000;
  localparam int unsigned PERCENT_FULL = 100;

  localparam int unsigned SPEED_W   = 11;
  localparam int unsigned PERCENT_W = 7;
  localparam int unsigned MINSPD_W  = 10;
  localparam int unsigned QUOT_BITS = 10;  // scaled axis magnitude, at most 1000

  // divider: quotient bits resolved per pipeline stage
  localparam int unsigned DIV_STEP   = 2;
  localparam int unsigned DIV_STAGES = QUOT_BITS / DIV_STEP;

  // divide by 100 as multiply by ceil(2^24/100), exact for products below 199728
  localparam int unsigned PROD_W      = QUOT_BITS + PERCENT_W;
  localparam int unsigned RECIP_100   = 167773;
  localparam int unsigned RECIP_W     = 18;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RPROD_W     = PROD_W + RECIP_W;

  // edges from accepted start to the edge that takes the result
  localparam int unsigned PIPE_LATENCY = DIV_STAGES + 6;

  // configuration register reset values
  localparam int unsigned RST_CENTER_X  = 2220;
  localparam int unsigned RST_CENTER_Y  = 2195;
  localparam int unsigned RST_DEADBAND  = 300;
  localparam int unsigned RST_THR_SPAN  = 1720;
  localparam int unsigned RST_STR_SPAN  = 1900;
  localparam int unsigned RST_PERCENT   = 25;
  localparam int unsigned RST_MIN_SPEED = 30;

  typedef enum logic [2:0] {
    REG_CENTER_X      = 3'd0,
    REG_CENTER_Y      = 3'd1,
    REG_DEADBAND_X    = 3'd2,
    REG_DEADBAND_Y    = 3'd3,
    REG_THROTTLE_SPAN = 3'd4,
    REG_STEERING_SPAN = 3'd5,
    REG_STEER_PERCENT = 3'd6,
    REG_MIN_SPEED     = 3'd7
  } cfg_reg_t;

endpackage

`default_nettype wire

[hw/rtl/joystick_arcade_drive_mixer.sv]
// joystick arcade drive mixer
//
// command channel: a sample pair is taken at a rising edge with start high
// and busy low; busy is never raised, so a new pair may be presented every
// cycle. each result (left_cmd, right_cmd, drive_enabled) is shown for
// exactly one cycle with done high, and the receiver cannot hold it off.
// pipeline: each pair taken passes in order through deadband and
// centring, clamp and scale by 1000, five divider stages of two quotient
// bits each, steering percentage product, divide by 100, mix and clamp,
// minimum speed. throughput is one transaction per cycle, set by the
// pipelined restoring divider for the span division.
// configuration: cfg_valid/cfg_ready write channel, cfg_ready always high,
// cfg_index picks the register, cfg_data holds its value in the low bits.
// registers are to be written only while the pipeline is empty.
// reset: all pipeline valid bits and done clear, registers take their
// default values; the block accepts pairs in the cycle after reset drops.
`default_nettype none

module joystick_arcade_drive_mixer #(
  parameter int unsigned SAMPLE_BITS = jadm_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned CfgW = (SAMPLE_BITS > jadm_pkg::MINSPD_W) ?
                                 SAMPLE_BITS : jadm_pkg::MINSPD_W
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [SAMPLE_BITS-1:0]              x_sample,
  input  wire logic [SAMPLE_BITS-1:0]              y_sample,
  output logic                                     done,
  output logic signed [jadm_pkg::SPEED_W-1:0]      left_cmd,
  output logic signed [jadm_pkg::SPEED_W-1:0]      right_cmd,
  output logic                                     drive_enabled,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire jadm_pkg::cfg_reg_t                  cfg_index,
  input  wire logic [CfgW-1:0]                     cfg_data
);
  import jadm_pkg::*;

  localparam int unsigned SampleW = SAMPLE_BITS;
  localparam int unsigned DivW    = SAMPLE_BITS + QUOT_BITS;  // span * 1000 fits
  localparam int unsigned MixW    = SPEED_W + 2;

  // configuration registers
  logic [SampleW-1:0]   rest_x;
  logic [SampleW-1:0]   rest_y;
  logic [SampleW-1:0]   dead_half_x;
  logic [SampleW-1:0]   dead_half_y;
  logic [SampleW-1:0]   throttle_span;
  logic [SampleW-1:0]   steering_span;
  logic [PERCENT_W-1:0] steering_percent;
  logic [MINSPD_W-1:0]  speed_floor;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rest_x           <= SampleW'(RST_CENTER_X);
      rest_y           <= SampleW'(RST_CENTER_Y);
      dead_half_x      <= SampleW'(RST_DEADBAND);
      dead_half_y      <= SampleW'(RST_DEADBAND);
      throttle_span    <= SampleW'(RST_THR_SPAN);
      steering_span    <= SampleW'(RST_STR_SPAN);
      steering_percent <= PERCENT_W'(RST_PERCENT);
      speed_floor      <= MINSPD_W'(RST_MIN_SPEED);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CENTER_X:      rest_x           <= cfg_data[SampleW-1:0];
        REG_CENTER_Y:      rest_y           <= cfg_data[SampleW-1:0];
        REG_DEADBAND_X:    dead_half_x      <= cfg_data[SampleW-1:0];
        REG_DEADBAND_Y:    dead_half_y      <= cfg_data[SampleW-1:0];
        REG_THROTTLE_SPAN: throttle_span    <= cfg_data[SampleW-1:0];
        REG_STEERING_SPAN: steering_span    <= cfg_data[SampleW-1:0];
        REG_STEER_PERCENT: steering_percent <= cfg_data[PERCENT_W-1:0];
        REG_MIN_SPEED:     speed_floor      <= cfg_data[MINSPD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: dead window test (signed bounds, no wrap) and axis centring
  // ---------------------------------------------------------------------
  logic signed [SampleW+1:0] x_ext, y_ext, cx_ext, cy_ext, dx_ext, dy_ext;
  logic                      in_dead;

  always_comb begin
    x_ext   = $signed({2'b00, x_sample});
    y_ext   = $signed({2'b00, y_sample});
    cx_ext  = $signed({2'b00, rest_x});
    cy_ext  = $signed({2'b00, rest_y});
    dx_ext  = $signed({2'b00, dead_half_x});
    dy_ext  = $signed({2'b00, dead_half_y});
    in_dead = (x_ext > cx_ext - dx_ext) && (x_ext < cx_ext + dx_ext) &&
              (y_ext > cy_ext - dy_ext) && (y_ext < cy_ext + dy_ext);
  end

  logic                    s1_valid;
  logic                    s1_dead;
  logic signed [SampleW:0] s1_thr;  // rest_x - x, throttle with x inverted
  logic signed [SampleW:0] s1_str;  // y - rest_y

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_dead <= in_dead;
    s1_thr  <= $signed({1'b0, rest_x}) - $signed({1'b0, x_sample});
    s1_str  <= $signed({1'b0, y_sample}) - $signed({1'b0, rest_y});
  end

  // ---------------------------------------------------------------------
  // stage 2: clamp magnitude to span, scale by 1000 ahead of the divider;
  // division runs on magnitudes so the quotient truncates toward zero
  // ---------------------------------------------------------------------
  logic               thr_neg, str_neg;
  logic [SampleW-1:0] thr_mag, str_mag, thr_clamp, str_clamp;

  always_comb begin
    thr_neg   = s1_thr[SampleW];
    str_neg   = s1_str[SampleW];
    thr_mag   = thr_neg ? SampleW'(-s1_thr) : SampleW'(s1_thr);
    str_mag   = str_neg ? SampleW'(-s1_str) : SampleW'(s1_str);
    thr_clamp = (thr_mag > throttle_span) ? throttle_span : thr_mag;
    str_clamp = (str_mag > steering_span) ? steering_span : str_mag;
  end

  // divider pipeline, entry 0 loaded here, one entry per stage after it
  logic                 dv_valid    [0:DIV_STAGES];
  logic                 dv_dead     [0:DIV_STAGES];
  logic                 dv_thr_neg  [0:DIV_STAGES];
  logic                 dv_str_neg  [0:DIV_STAGES];
  logic                 dv_thr_zero [0:DIV_STAGES];
  logic                 dv_str_zero [0:DIV_STAGES];
  logic [DivW-1:0]      dv_thr_rem  [0:DIV_STAGES];
  logic [DivW-1:0]      dv_str_rem  [0:DIV_STAGES];
  logic [QUOT_BITS-1:0] dv_thr_q    [0:DIV_STAGES];
  logic [QUOT_BITS-1:0] dv_str_q    [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else begin
      dv_valid[0] <= s1_valid;
    end
    dv_dead[0]     <= s1_dead;
    dv_thr_neg[0]  <= thr_neg;
    dv_str_neg[0]  <= str_neg;
    dv_thr_zero[0] <= (throttle_span == '0);
    dv_str_zero[0] <= (steering_span == '0);
    dv_thr_rem[0]  <= DivW'(thr_clamp) * DivW'(MOTOR_MAX);
    dv_str_rem[0]  <= DivW'(str_clamp) * DivW'(MOTOR_MAX);
    dv_thr_q[0]    <= '0;
    dv_str_q[0]    <= '0;
  end

  // ---------------------------------------------------------------------
  // stages 3 .. 2+DIV_STAGES: restoring division, DIV_STEP bits per stage;
  // dividend is below 1024 * span so ten quotient bits cover it
  // ---------------------------------------------------------------------
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    logic [DivW-1:0]      thr_r, str_r, thr_d, str_d;
    logic [QUOT_BITS-1:0] thr_qn, str_qn;

    always_comb begin
      thr_r  = dv_thr_rem[g];
      str_r  = dv_str_rem[g];
      thr_qn = dv_thr_q[g];
      str_qn = dv_str_q[g];
      thr_d  = '0;
      str_d  = '0;
      for (int j = 0; j < DIV_STEP; j++) begin
        thr_d = DivW'(throttle_span) << (QUOT_BITS - 1 - (g * DIV_STEP + j));
        str_d = DivW'(steering_span) << (QUOT_BITS - 1 - (g * DIV_STEP + j));
        if (thr_r >= thr_d) begin
          thr_r = thr_r - thr_d;
          thr_qn[QUOT_BITS - 1 - (g * DIV_STEP + j)] = 1'b1;
        end
        if (str_r >= str_d) begin
          str_r = str_r - str_d;
          str_qn[QUOT_BITS - 1 - (g * DIV_STEP + j)] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[g+1] <= 1'b0;
      end else begin
        dv_valid[g+1] <= dv_valid[g];
      end
      dv_dead[g+1]     <= dv_dead[g];
      dv_thr_neg[g+1]  <= dv_thr_neg[g];
      dv_str_neg[g+1]  <= dv_str_neg[g];
      dv_thr_zero[g+1] <= dv_thr_zero[g];
      dv_str_zero[g+1] <= dv_str_zero[g];
      dv_thr_rem[g+1]  <= thr_r;
      dv_str_rem[g+1]  <= str_r;
      dv_thr_q[g+1]    <= thr_qn;
      dv_str_q[g+1]    <= str_qn;
    end
  end

  // ---------------------------------------------------------------------
  // signed throttle, and steering magnitude times percentage
  // ---------------------------------------------------------------------
  logic [QUOT_BITS-1:0] thr_q_fin, str_q_fin;

  always_comb begin
    // a zero span scales the axis to zero
    thr_q_fin = dv_thr_zero[DIV_STAGES] ? '0 : dv_thr_q[DIV_STAGES];
    str_q_fin = dv_str_zero[DIV_STAGES] ? '0 : dv_str_q[DIV_STAGES];
  end

  logic                      s8_valid;
  logic                      s8_dead;
  logic signed [SPEED_W-1:0] s8_thr;
  logic                      s8_str_neg;
  logic [PROD_W-1:0]         s8_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else begin
      s8_valid <= dv_valid[DIV_STAGES];
    end
    s8_dead    <= dv_dead[DIV_STAGES];
    s8_thr     <= dv_thr_neg[DIV_STAGES] ? -$signed({1'b0, thr_q_fin}) :
                                            $signed({1'b0, thr_q_fin});
    s8_str_neg <= dv_str_neg[DIV_STAGES];
    s8_prod    <= PROD_W'(str_q_fin) * PROD_W'(steering_percent);
  end

  // ---------------------------------------------------------------------
  // divide the steering product by 100 via reciprocal multiply
  // ---------------------------------------------------------------------
  logic [RPROD_W-1:0]            recip_prod;
  logic [RPROD_W-RECIP_SHIFT-1:0] str_pct;

  always_comb begin
    recip_prod = RPROD_W'(s8_prod) * RPROD_W'(RECIP_100);
    str_pct    = recip_prod[RPROD_W-1:RECIP_SHIFT];
  end

  logic                                 s9_valid;
  logic                                 s9_dead;
  logic signed [SPEED_W-1:0]            s9_thr;
  logic signed [RPROD_W-RECIP_SHIFT:0]  s9_str;

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_valid <= 1'b0;
    end else begin
      s9_valid <= s8_valid;
    end
    s9_dead <= s8_dead;
    s9_thr  <= s8_thr;
    s9_str  <= s8_str_neg ? -$signed({1'b0, str_pct}) : $signed({1'b0, str_pct});
  end

  // ---------------------------------------------------------------------
  // mix as sum and difference, clamp to the motor range
  // ---------------------------------------------------------------------
  logic signed [MixW-1:0]    mix_l, mix_r;
  logic signed [SPEED_W-1:0] clamp_l, clamp_r;

  always_comb begin
    mix_l = MixW'(s9_thr) + MixW'(s9_str);
    mix_r = MixW'(s9_thr) - MixW'(s9_str);
    if (mix_l > $signed(MixW'(MOTOR_MAX))) begin
      clamp_l = SPEED_W'(MOTOR_MAX);
    end else if (mix_l < -$signed(MixW'(MOTOR_MAX))) begin
      clamp_l = -$signed(SPEED_W'(MOTOR_MAX));
    end else begin
      clamp_l = SPEED_W'(mix_l);
    end
    if (mix_r > $signed(MixW'(MOTOR_MAX))) begin
      clamp_r = SPEED_W'(MOTOR_MAX);
    end else if (mix_r < -$signed(MixW'(MOTOR_MAX))) begin
      clamp_r = -$signed(SPEED_W'(MOTOR_MAX));
    end else begin
      clamp_r = SPEED_W'(mix_r);
    end
  end

  logic                      s10_valid;
  logic                      s10_dead;
  logic signed [SPEED_W-1:0] s10_left, s10_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_valid <= 1'b0;
    end else begin
      s10_valid <= s9_valid;
    end
    s10_dead  <= s9_dead;
    s10_left  <= clamp_l;
    s10_right <= clamp_r;
  end

  // ---------------------------------------------------------------------
  // minimum speed, dead window override, output register
  // ---------------------------------------------------------------------
  logic [SPEED_W-1:0]        mag_l, mag_r;
  logic signed [SPEED_W-1:0] fin_l, fin_r;

  always_comb begin
    mag_l = s10_left[SPEED_W-1]  ? SPEED_W'(-s10_left)  : SPEED_W'(s10_left);
    mag_r = s10_right[SPEED_W-1] ? SPEED_W'(-s10_right) : SPEED_W'(s10_right);
    fin_l = (s10_dead || mag_l < SPEED_W'(speed_floor)) ? '0 : s10_left;
    fin_r = (s10_dead || mag_r < SPEED_W'(speed_floor)) ? '0 : s10_right;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s10_valid;
    end
    left_cmd      <= fin_l;
    right_cmd     <= fin_r;
    drive_enabled <= (fin_l != '0) || (fin_r != '0);
  end

endmodule

`default_nettype wire

[hw/rtl/jadm_checker.sv]
`default_nettype none
`include "joystick_arcade_drive_mixer_macros.svh"

module jadm_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic                               done,
  input wire logic signed [jadm_pkg::SPEED_W-1:0] left_cmd,
  input wire logic signed [jadm_pkg::SPEED_W-1:0] right_cmd,
  input wire logic                               drive_enabled
);
  import jadm_pkg::*;

  // every result strobe goes back to a transaction a fixed depth earlier
  `JADM_ASSERT_IMP(a_done_has_start, clk, rst, done, $past(start && !busy, PIPE_LATENCY))

  // enable flag agrees with the speeds it reports
  `JADM_ASSERT_IMP(a_enable_match, clk, rst, done, drive_enabled == |{left_cmd, right_cmd})

  // speeds stay inside the motor range
  `JADM_ASSERT_IMP(a_left_range, clk, rst, done, (left_cmd <= 11'sd1000) && (left_cmd >= -11'sd1000))
  `JADM_ASSERT_IMP(a_right_range, clk, rst, done, (right_cmd <= 11'sd1000) && (right_cmd >= -11'sd1000))

endmodule

bind joystick_arcade_drive_mixer jadm_checker u_jadm_checker (.*);

`default_nettype wire

[tb/sv/tb_top.sv]
module tb_top;
  import jadm_pkg::*;

  // generous ceiling: ~1350 transactions with their idle gaps plus pipeline drains
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 165;

  // one stimulus entry: the sample pair, the idle cycles before it, and whether
  // the sender must hold off until every outstanding result has come back
  typedef struct {
    logic [11:0] x;
    logic [11:0] y;
    int unsigned gap;
    bit          drain;
  } sample_pair_t;

  // one motor command as the block should emit it
  typedef struct {
    logic signed [10:0] left;
    logic signed [10:0] right;
    logic               en;
  } drive_cmd_t;

  // shadow of the register file
  typedef struct {
    logic [11:0] cx;
    logic [11:0] cy;
    logic [11:0] dx;
    logic [11:0] dy;
    logic [11:0] tspan;
    logic [11:0] sspan;
    logic [6:0]  pct;
    logic [9:0]  minspd;
  } mix_cfg_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [11:0]        x_sample = '0;
  logic [11:0]        y_sample = '0;
  logic               done;
  logic signed [10:0] left_cmd;
  logic signed [10:0] right_cmd;
  logic               drive_enabled;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  cfg_reg_t           cfg_index = REG_CENTER_X;
  logic [11:0]        cfg_data = '0;

  sample_pair_t pending_pairs[$];   // stimulus not yet handed to the driver
  drive_cmd_t   pending_speeds[$];  // predicted commands awaiting the block's output
  mix_cfg_t     live_cfg;           // register contents as the block holds them
  sample_pair_t staged_pair;        // entry the driver is counting its gap down for
  bit           staged_valid = 1'b0;
  int unsigned  gap_left = 0;
  int unsigned  n_mismatch = 0;
  int unsigned  n_cycles = 0;

  joystick_arcade_drive_mixer u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .x_sample      (x_sample),
    .y_sample      (y_sample),
    .done          (done),
    .left_cmd      (left_cmd),
    .right_cmd     (right_cmd),
    .drive_enabled (drive_enabled),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // power-on register values
  function automatic mix_cfg_t default_cfg();
    mix_cfg_t c;
    c.cx     = 12'(RST_CENTER_X);
    c.cy     = 12'(RST_CENTER_Y);
    c.dx     = 12'(RST_DEADBAND);
    c.dy     = 12'(RST_DEADBAND);
    c.tspan  = 12'(RST_THR_SPAN);
    c.sspan  = 12'(RST_STR_SPAN);
    c.pct    = 7'(RST_PERCENT);
    c.minspd = 10'(RST_MIN_SPEED);
    return c;
  endfunction

  // clamp a centred deflection to the span and scale it to motor units;
  // a zero span gives nothing rather than dividing
  function automatic int scale_to_motor(int deflection, int span);
    int d;
    if (span == 0) return 0;
    d = (deflection < -span) ? -span : (deflection > span) ? span : deflection;
    return (d * int'(MOTOR_MAX)) / span;
  endfunction

  function automatic int clamp_motor(int v);
    if (v < -int'(MOTOR_MAX)) return -int'(MOTOR_MAX);
    if (v > int'(MOTOR_MAX)) return int'(MOTOR_MAX);
    return v;
  endfunction

  // arcade mix of one sample pair under configuration c
  function automatic drive_cmd_t mix_speeds(mix_cfg_t c, logic [11:0] xs, logic [11:0] ys);
    drive_cmd_t r;
    int x, y, cx, cy, dx, dy, thr, steer, lft, rgt, mn;
    x  = int'(xs);
    y  = int'(ys);
    cx = int'(c.cx);
    cy = int'(c.cy);
    dx = int'(c.dx);
    dy = int'(c.dy);
    mn = int'(c.minspd);
    // dead window: strict bounds, computed signed so they never wrap
    if (x > cx - dx && x < cx + dx && y > cy - dy && y < cy + dy) begin
      r.left  = '0;
      r.right = '0;
      r.en    = 1'b0;
      return r;
    end
    // x axis inverted: low samples mean forward
    thr   = scale_to_motor(cx - x, int'(c.tspan));
    steer = scale_to_motor(y - cy, int'(c.sspan));
    // percentage taken as given, even above a hundred
    steer = (steer * int'(c.pct)) / int'(PERCENT_FULL);
    lft   = clamp_motor(thr + steer);
    rgt   = clamp_motor(thr - steer);
    if ((lft < 0 ? -lft : lft) < mn) lft = 0;
    if ((rgt < 0 ? -rgt : rgt) < mn) rgt = 0;
    r.left  = 11'(lft);
    r.right = 11'(rgt);
    r.en    = (lft != 0) || (rgt != 0);
    return r;
  endfunction

  function automatic logic [11:0] clip12(int v);
    if (v < 0) return 12'd0;
    if (v > 4095) return 12'd4095;
    return 12'(v);
  endfunction

  // random pair, biased towards the dead window edges and the rails
  function automatic sample_pair_t pick_pair(mix_cfg_t c);
    sample_pair_t p;
    int ox, oy;
    p.gap   = 0;
    p.drain = 1'b0;
    case ($urandom_range(0, 9))
      4, 5, 6: begin
        // on or beside a window boundary, or at the centre, on each axis
        ox = ($urandom_range(0, 2) == 0) ? -int'(c.dx) :
             ($urandom_range(0, 1) == 0) ? int'(c.dx) : 0;
        oy = ($urandom_range(0, 2) == 0) ? -int'(c.dy) :
             ($urandom_range(0, 1) == 0) ? int'(c.dy) : 0;
        p.x = clip12(int'(c.cx) + ox + $urandom_range(0, 4) - 2);
        p.y = clip12(int'(c.cy) + oy + $urandom_range(0, 4) - 2);
      end
      7: begin
        p.x = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
        p.y = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
      end
      8: begin
        // somewhere inside the window
        p.x = clip12(int'(c.cx) + $urandom_range(0, 2 * int'(c.dx)) - int'(c.dx));
        p.y = clip12(int'(c.cy) + $urandom_range(0, 2 * int'(c.dy)) - int'(c.dy));
      end
      9: begin
        p.x = 12'($urandom);
        p.y = c.cy;
      end
      default: begin
        p.x = 12'($urandom);
        p.y = 12'($urandom);
      end
    endcase
    return p;
  endfunction

  // random register set, with the extremes drawn now and then
  function automatic mix_cfg_t pick_cfg();
    mix_cfg_t c;
    c.cx    = 12'($urandom);
    c.cy    = 12'($urandom);
    c.dx    = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 500));
    c.dy    = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 500));
    c.tspan = ($urandom_range(0, 7) == 0) ? 12'd0 :
              ($urandom_range(0, 6) == 0) ? 12'($urandom_range(1, 16)) : 12'($urandom);
    c.sspan = ($urandom_range(0, 7) == 0) ? 12'd0 :
              ($urandom_range(0, 6) == 0) ? 12'($urandom_range(1, 16)) : 12'($urandom);
    c.pct   = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 100));
    c.minspd = ($urandom_range(0, 5) == 0) ? 10'($urandom) : 10'($urandom_range(0, 100));
    return c;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    n_mismatch++;
  endtask

  task automatic push_pair(logic [11:0] x, logic [11:0] y, int unsigned gap, bit drain);
    sample_pair_t p;
    p.x     = x;
    p.y     = y;
    p.gap   = gap;
    p.drain = drain;
    pending_pairs.push_back(p);
  endtask

  // one register write transaction on the config channel
  task automatic write_reg(cfg_reg_t idx, logic [11:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_regs(mix_cfg_t c);
    write_reg(REG_CENTER_X, c.cx);
    write_reg(REG_CENTER_Y, c.cy);
    write_reg(REG_DEADBAND_X, c.dx);
    write_reg(REG_DEADBAND_Y, c.dy);
    write_reg(REG_THROTTLE_SPAN, c.tspan);
    write_reg(REG_STEERING_SPAN, c.sspan);
    write_reg(REG_STEER_PERCENT, 12'(c.pct));
    write_reg(REG_MIN_SPEED, 12'(c.minspd));
  endtask

  // every transaction sent and every result back: safe to touch registers;
  // checked on the falling edge so the driver's updates have settled
  task automatic wait_idle();
    @(negedge clk);
    while (pending_pairs.size() != 0 || staged_valid || start || pending_speeds.size() != 0)
      @(negedge clk);
  endtask

  // register shadow follows each accepted write transaction
  always @(posedge clk) begin
    if (rst) begin
      live_cfg <= default_cfg();
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CENTER_X:      live_cfg.cx     <= cfg_data;
        REG_CENTER_Y:      live_cfg.cy     <= cfg_data;
        REG_DEADBAND_X:    live_cfg.dx     <= cfg_data;
        REG_DEADBAND_Y:    live_cfg.dy     <= cfg_data;
        REG_THROTTLE_SPAN: live_cfg.tspan  <= cfg_data;
        REG_STEERING_SPAN: live_cfg.sspan  <= cfg_data;
        REG_STEER_PERCENT: live_cfg.pct    <= cfg_data[6:0];
        REG_MIN_SPEED:     live_cfg.minspd <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // driver: predicts each accepted pair, then counts down the next entry's gap
  // before raising start; start is assigned once per edge so a back-to-back
  // transaction keeps it high without a glitch
  always @(posedge clk) begin : drv
    logic nxt_start;
    nxt_start = start;
    if (rst) begin
      nxt_start    = 1'b0;
      staged_valid = 1'b0;
    end else begin
      if (start && !busy) begin
        pending_speeds.push_back(mix_speeds(live_cfg, x_sample, y_sample));
        nxt_start = 1'b0;
      end
      if (!nxt_start) begin
        if (!staged_valid && pending_pairs.size() != 0) begin
          staged_pair  = pending_pairs.pop_front();
          staged_valid = 1'b1;
          gap_left     = staged_pair.gap;
        end
        if (staged_valid) begin
          if (gap_left != 0) begin
            gap_left--;
          end else if (!(staged_pair.drain && pending_speeds.size() != 0)) begin
            // a draining entry holds off until the pipeline has emptied
            x_sample     <= staged_pair.x;
            y_sample     <= staged_pair.y;
            nxt_start    = 1'b1;
            staged_valid = 1'b0;
          end
        end
      end
    end
    start <= nxt_start;
  end

  // monitor: each done cycle is one result transaction, checked against the
  // oldest prediction
  always @(posedge clk) begin : mon
    drive_cmd_t want;
    if (!rst && done) begin
      if (pending_speeds.size() == 0) begin
        report_mismatch($sformatf("unexpected result left=%0d right=%0d en=%0b",
                                  left_cmd, right_cmd, drive_enabled));
      end else begin
        want = pending_speeds.pop_front();
        if (left_cmd !== want.left)
          report_mismatch($sformatf("left_cmd got %0d want %0d", left_cmd, want.left));
        if (right_cmd !== want.right)
          report_mismatch($sformatf("right_cmd got %0d want %0d", right_cmd, want.right));
        if (drive_enabled !== want.en)
          report_mismatch($sformatf("drive_enabled got %0b want %0b", drive_enabled, want.en));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    mix_cfg_t     c;
    sample_pair_t p;
    bit           burst_phase;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // power-on settings: rails, centre, and each dead window edge
    // (one pixel out is live, one pixel in is dead)
    push_pair(12'd0, 12'd0, $urandom_range(0, 7), 1'b0);
    push_pair(12'd4095, 12'd4095, 0, 1'b0);
    push_pair(12'd0, 12'd4095, 0, 1'b0);
    push_pair(12'd4095, 12'd0, $urandom_range(0, 7), 1'b0);
    push_pair(12'd2220, 12'd2195, $urandom_range(0, 7), 1'b0);
    push_pair(12'd1920, 12'd2195, 0, 1'b0);
    push_pair(12'd1921, 12'd2195, $urandom_range(0, 7), 1'b0);
    push_pair(12'd2519, 12'd2494, 0, 1'b0);
    push_pair(12'd2520, 12'd2195, $urandom_range(0, 7), 1'b1);
    push_pair(12'd2220, 12'd1895, 0, 1'b0);
    push_pair(12'd2220, 12'd2494, $urandom_range(0, 7), 1'b0);
    wait_idle();

    // both spans zero, no dead window, centres on the rails
    c        = default_cfg();
    c.cx     = 12'd0;
    c.cy     = 12'd4095;
    c.dx     = 12'd0;
    c.dy     = 12'd0;
    c.tspan  = 12'd0;
    c.sspan  = 12'd0;
    c.pct    = 7'd127;
    c.minspd = 10'd0;
    program_regs(c);
    push_pair(12'd0, 12'd4095, $urandom_range(0, 7), 1'b0);
    push_pair(12'd4095, 12'd0, 0, 1'b0);
    wait_idle();

    // unit spans, widest windows, minimum speed above full scale
    c.cx     = 12'd4095;
    c.cy     = 12'd0;
    c.dx     = 12'd4095;
    c.dy     = 12'd4095;
    c.tspan  = 12'd1;
    c.sspan  = 12'd1;
    c.minspd = 10'd1023;
    program_regs(c);
    push_pair(12'd4095, 12'd0, 0, 1'b0);
    push_pair(12'd0, 12'd4095, $urandom_range(0, 7), 1'b0);
    push_pair(12'd10, 12'd4095, 0, 1'b0);
    wait_idle();

    // full spans with steering percentage past a hundred
    c        = default_cfg();
    c.tspan  = 12'd4095;
    c.sspan  = 12'd4095;
    c.pct    = 7'd127;
    c.minspd = 10'd0;
    program_regs(c);
    push_pair(12'd0, 12'd4095, 0, 1'b0);
    push_pair(12'd4095, 12'd0, $urandom_range(0, 7), 1'b0);
    push_pair(12'd0, 12'd0, 0, 1'b0);
    wait_idle();

    // random phases: first back at power-on values, then random register sets;
    // odd phases carry a stretch of back-to-back transactions
    for (int ph = 0; ph < PHASES; ph++) begin
      c = (ph == 0) ? default_cfg() : pick_cfg();
      program_regs(c);
      burst_phase = ph[0];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        p       = pick_pair(c);
        p.gap   = (burst_phase && i >= 40 && i < 90) ? 0 : $urandom_range(0, 7);
        p.drain = ($urandom_range(0, 99) == 0);
        pending_pairs.push_back(p);
      end
      wait_idle();
    end

    // let any stray result surface
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (pending_speeds.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_speeds.size()));

    if (n_mismatch == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
